// File: src/gqi_pkg.sv
// Shared types, datapath command codes and product table for the gyro
// quaternion integrator. No dependencies.
package gqi_pkg;

  localparam int unsigned GyroW  = 16;
  localparam int unsigned QuatW  = 32;
  localparam int unsigned ScaleW = 32;
  localparam int unsigned AccW   = 36;  // updated component before normalization
  localparam int unsigned MagW   = 35;
  localparam int unsigned MulW   = 33;
  localparam int unsigned ProdW  = 2 * MulW;

  localparam logic [ScaleW-1:0] ScaleReset = 32'd183;
  localparam logic [QuatW-1:0]  QuatOne    = 32'h4000_0000;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_RATE_MUL,
    DP_RATE_ACC,
    DP_PROD_MUL,
    DP_PROD_ACC,
    DP_MAG,
    DP_SHR,
    DP_SHL,
    DP_IDENT,
    DP_SQ_MUL,
    DP_SQ_ACC,
    DP_SQRT_INIT,
    DP_SQRT_STEP,
    DP_DIV_INIT,
    DP_DIV_STEP,
    DP_DIV_DONE,
    DP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [3:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic zero;   // all updated components are zero
    logic big;    // largest magnitude at or above 2^31
    logic low;    // largest magnitude below 2^30
  } dp_stat_t;

  // One term of the quaternion product: c[k] +/- round(q[j] * a[i]).
  typedef struct packed {
    logic [1:0] k;
    logic [1:0] j;
    logic [1:0] i;
    logic       sub;
  } prod_term_t;

  function automatic prod_term_t prod_term(input logic [3:0] t);
    prod_term_t r;
    case (t)
      4'd0:    r = '{k: 2'd0, j: 2'd1, i: 2'd0, sub: 1'b1};
      4'd1:    r = '{k: 2'd0, j: 2'd2, i: 2'd1, sub: 1'b1};
      4'd2:    r = '{k: 2'd0, j: 2'd3, i: 2'd2, sub: 1'b1};
      4'd3:    r = '{k: 2'd1, j: 2'd0, i: 2'd0, sub: 1'b0};
      4'd4:    r = '{k: 2'd1, j: 2'd2, i: 2'd2, sub: 1'b1};
      4'd5:    r = '{k: 2'd1, j: 2'd3, i: 2'd1, sub: 1'b0};
      4'd6:    r = '{k: 2'd2, j: 2'd0, i: 2'd1, sub: 1'b0};
      4'd7:    r = '{k: 2'd2, j: 2'd1, i: 2'd2, sub: 1'b0};
      4'd8:    r = '{k: 2'd2, j: 2'd3, i: 2'd0, sub: 1'b1};
      4'd9:    r = '{k: 2'd3, j: 2'd0, i: 2'd2, sub: 1'b0};
      4'd10:   r = '{k: 2'd3, j: 2'd1, i: 2'd1, sub: 1'b1};
      4'd11:   r = '{k: 2'd3, j: 2'd2, i: 2'd0, sub: 1'b0};
      default: r = '{k: 2'd0, j: 2'd0, i: 2'd0, sub: 1'b0};
    endcase
    return r;
  endfunction

endpackage

// File: src/gqi_ctrl.sv
// Sequencer for the gyro quaternion integrator: steps the datapath through
// rate, product, normalize, square root and divide phases. Uses gqi_pkg.
module gqi_ctrl import gqi_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     out_ready_i,
  output logic     out_valid_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RATE  = 9'b000000010,
    S_PROD  = 9'b000000100,
    S_MAG   = 9'b000001000,
    S_SHIFT = 9'b000010000,
    S_SQ    = 9'b000100000,
    S_SQRT  = 9'b001000000,
    S_DIV   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_e;

  state_e     state_q, state_d;
  logic [5:0] step_q, step_d;
  logic [1:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    cmd_o       = '{op: DP_NOP, idx: 4'd0};
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = DP_LOAD;
          step_d   = '0;
          state_d  = S_RATE;
        end
      end
      S_RATE: begin
        cmd_o.op  = step_q[0] ? DP_RATE_ACC : DP_RATE_MUL;
        cmd_o.idx = {2'b00, step_q[2:1]};
        step_d    = step_q + 6'd1;
        if (step_q == 6'd5) begin
          step_d  = '0;
          state_d = S_PROD;
        end
      end
      S_PROD: begin
        cmd_o.op  = step_q[0] ? DP_PROD_ACC : DP_PROD_MUL;
        cmd_o.idx = step_q[4:1];
        step_d    = step_q + 6'd1;
        if (step_q == 6'd23) begin
          state_d = S_MAG;
        end
      end
      S_MAG: begin
        cmd_o.op = DP_MAG;
        state_d  = S_SHIFT;
      end
      S_SHIFT: begin
        if (stat_i.zero) begin
          cmd_o.op = DP_IDENT;
          state_d  = S_OUT;
        end else if (stat_i.big) begin
          cmd_o.op = DP_SHR;
        end else if (stat_i.low) begin
          cmd_o.op = DP_SHL;
        end else begin
          step_d  = '0;
          state_d = S_SQ;
        end
      end
      S_SQ: begin
        cmd_o.op  = step_q[0] ? DP_SQ_ACC : DP_SQ_MUL;
        cmd_o.idx = {2'b00, step_q[2:1]};
        step_d    = step_q + 6'd1;
        if (step_q == 6'd7) begin
          step_d  = '0;
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd_o.op = (step_q == 6'd0) ? DP_SQRT_INIT : DP_SQRT_STEP;
        step_d   = step_q + 6'd1;
        if (step_q == 6'd32) begin
          step_d  = '0;
          idx_d   = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.idx = {2'b00, idx_q};
        step_d    = step_q + 6'd1;
        if (step_q == 6'd0) begin
          cmd_o.op = DP_DIV_INIT;
        end else if (step_q == 6'd33) begin
          cmd_o.op = DP_DIV_DONE;
          step_d   = '0;
          idx_d    = idx_q + 2'd1;
          if (idx_q == 2'd3) begin
            state_d = S_OUT;
          end
        end else begin
          cmd_o.op = DP_DIV_STEP;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = DP_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: src/gqi_dpath.sv
// Datapath of the gyro quaternion integrator: one shared multiplier, the
// attitude registers, shift normalizer, bit-serial root and divider. Uses gqi_pkg.
module gqi_dpath import gqi_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dp_cmd_t               cmd_i,
  output dp_stat_t              stat_o,
  input  logic                  cfg_we_i,
  input  logic [ScaleW-1:0]     cfg_data_i,
  input  logic [3*GyroW-1:0]    gyro_i,
  output logic [4*QuatW-1:0]    quat_o
);

  logic [ScaleW-1:0]          scale_q;
  logic signed [GyroW-1:0]    gx_q, gy_q, gz_q;
  logic signed [QuatW-1:0]    rate_q [3];
  logic signed [QuatW-1:0]    quat_q [4];
  logic signed [AccW-1:0]     acc_q  [4];
  logic [MagW-1:0]            mag_q  [4];
  logic [3:0]                 neg_q;
  logic [MagW-1:0]            max_q;
  logic signed [ProdW-1:0]    prod_q;
  logic [63:0]                sum_q, root_q, bit_q;
  logic [31:0]                rem_q, numlo_q, quo_q;
  logic [4*QuatW-1:0]         out_q;

  logic signed [MulW-1:0]     mul_a, mul_b;
  logic signed [GyroW:0]      g_sel;
  prod_term_t                 term;
  logic [ProdW-1:0]           pmag, rate_r, prod_r;
  logic                       pneg;
  logic [QuatW-1:0]           rate_sat;
  logic signed [AccW-1:0]     term_v;
  logic [MagW-1:0]            abs_c [4];
  logic [MagW-1:0]            max01, max23, max_all;
  logic [64:0]                sq_trial;
  logic [31:0]                norm;
  logic [61:0]                num;
  logic [32:0]                div_trial;
  logic [31:0]                quo_sat;

  assign term = prod_term(cmd_i.idx);
  assign norm = root_q[31:0];

  always_comb begin
    case (cmd_i.idx[1:0])
      2'd0:    g_sel = -(17'(gy_q));
      2'd1:    g_sel = -(17'(gx_q));
      default: g_sel = 17'(gz_q);
    endcase
  end

  // Operand select for the shared multiplier.
  always_comb begin
    case (cmd_i.op)
      DP_RATE_MUL: begin
        mul_a = MulW'(g_sel);
        mul_b = $signed({1'b0, scale_q});
      end
      DP_PROD_MUL: begin
        mul_a = MulW'(quat_q[term.j]);
        mul_b = MulW'(rate_q[term.i]);
      end
      DP_SQ_MUL: begin
        mul_a = $signed({2'b00, mag_q[cmd_i.idx[1:0]][30:0]});
        mul_b = $signed({2'b00, mag_q[cmd_i.idx[1:0]][30:0]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Round half away from zero on the magnitude of the product.
  always_comb begin
    pneg   = prod_q[ProdW-1];
    pmag   = pneg ? 66'(-prod_q) : 66'(prod_q);
    rate_r = (pmag + 66'd512) >> 10;
    prod_r = (pmag + (66'd1 << 29)) >> 30;
    if (!pneg) begin
      rate_sat = (rate_r > 66'h7FFF_FFFF) ? 32'h7FFF_FFFF : rate_r[31:0];
    end else begin
      rate_sat = (rate_r > 66'h8000_0000) ? 32'h8000_0000 : -rate_r[31:0];
    end
    term_v = pneg ? -$signed(prod_r[AccW-1:0]) : $signed(prod_r[AccW-1:0]);
  end

  always_comb begin
    for (int n = 0; n < 4; n++) begin
      abs_c[n] = acc_q[n][AccW-1] ? MagW'(-acc_q[n]) : MagW'(acc_q[n]);
    end
    max01   = (abs_c[0] > abs_c[1]) ? abs_c[0] : abs_c[1];
    max23   = (abs_c[2] > abs_c[3]) ? abs_c[2] : abs_c[3];
    max_all = (max01 > max23) ? max01 : max23;
  end

  assign sq_trial  = {1'b0, root_q} + {1'b0, bit_q};
  assign num       = {1'b0, mag_q[cmd_i.idx[1:0]][30:0], 30'd0} + 62'(norm >> 1);
  assign div_trial = {rem_q, numlo_q[31]};
  assign quo_sat   = (quo_q > QuatOne) ? QuatOne : quo_q;

  assign stat_o.zero = (max_q == '0);
  assign stat_o.big  = (max_q[MagW-1:31] != '0);
  assign stat_o.low  = (max_q[MagW-1:30] == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q   <= ScaleReset;
      quat_q[0] <= QuatOne;
      quat_q[1] <= '0;
      quat_q[2] <= '0;
      quat_q[3] <= '0;
    end else begin
      if (cfg_we_i) begin
        scale_q <= cfg_data_i;
      end
      case (cmd_i.op)
        DP_IDENT: begin
          quat_q[0] <= QuatOne;
          quat_q[1] <= '0;
          quat_q[2] <= '0;
          quat_q[3] <= '0;
        end
        DP_DIV_DONE: begin
          quat_q[cmd_i.idx[1:0]] <= neg_q[cmd_i.idx[1:0]] ? -$signed(quo_sat)
                                                           : $signed(quo_sat);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (cmd_i.op)
      DP_LOAD: begin
        gx_q <= gyro_i[GyroW-1:0];
        gy_q <= gyro_i[2*GyroW-1:GyroW];
        gz_q <= gyro_i[3*GyroW-1:2*GyroW];
        for (int n = 0; n < 4; n++) begin
          acc_q[n] <= AccW'(quat_q[n]);
        end
      end
      DP_RATE_ACC: rate_q[cmd_i.idx[1:0]] <= rate_sat;
      DP_PROD_ACC: begin
        acc_q[term.k] <= term.sub ? acc_q[term.k] - term_v : acc_q[term.k] + term_v;
      end
      DP_MAG: begin
        for (int n = 0; n < 4; n++) begin
          mag_q[n] <= abs_c[n];
          neg_q[n] <= acc_q[n][AccW-1];
        end
        max_q <= max_all;
        sum_q <= '0;
      end
      DP_SHR: begin
        for (int n = 0; n < 4; n++) begin
          mag_q[n] <= mag_q[n] >> 1;
        end
        max_q <= max_q >> 1;
      end
      DP_SHL: begin
        for (int n = 0; n < 4; n++) begin
          mag_q[n] <= mag_q[n] << 1;
        end
        max_q <= max_q << 1;
      end
      DP_IDENT: max_q <= '0;
      DP_SQ_ACC: sum_q <= sum_q + prod_q[63:0];
      DP_SQRT_INIT: begin
        root_q <= '0;
        bit_q  <= 64'd1 << 62;
      end
      DP_SQRT_STEP: begin
        if ({1'b0, sum_q} >= sq_trial) begin
          sum_q  <= sum_q - sq_trial[63:0];
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      DP_DIV_INIT: begin
        rem_q   <= {2'b00, num[61:32]};
        numlo_q <= num[31:0];
        quo_q   <= '0;
      end
      DP_DIV_STEP: begin
        if (div_trial >= {1'b0, norm}) begin
          rem_q <= 32'(div_trial - {1'b0, norm});
          quo_q <= {quo_q[30:0], 1'b1};
        end else begin
          rem_q <= div_trial[31:0];
          quo_q <= {quo_q[30:0], 1'b0};
        end
        numlo_q <= numlo_q << 1;
      end
      DP_OUT: out_q <= {quat_q[3], quat_q[2], quat_q[1], quat_q[0]};
      default: ;
    endcase
  end

  assign quat_o = out_q;

endmodule

// File: src/gyro_quaternion_integrator.sv
// Gyro quaternion integrator: first-order attitude update with normalization.
// Each request passes the rate, product, shift, sum of squares, square root and
// divide phases; a collapsed quaternion skips to the identity after the shift check.
// One request at a time: the next can be taken once the result enters the output
// register, later while an earlier result still waits.
// Reset: identity attitude, scale 183, no result pending.
module gyro_quaternion_integrator import gqi_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [3*GyroW-1:0]   s_axis_tdata,  // gyro_x, gyro_y, gyro_z
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [4*QuatW-1:0]   m_axis_tdata,  // quat_w, quat_x, quat_y, quat_z
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [ScaleW-1:0]    cfg_data_i     // half_angle_scale
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Configuration writes land at once; the user must issue them only while idle, which the block does not enforce.
  assign cfg_ready_o = 1'b1;

  gqi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  gqi_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .gyro_i     (s_axis_tdata),
    .quat_o     (m_axis_tdata)
  );

  // Busy right after a request is taken.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while still busy");

  // A new result only appears when the sequencer was busy the cycle before.
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result without work");

  // Normalized scalar part never leaves plus or minus one.
  a_w_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[31:0]) <= $signed(QuatOne)) &&
                      ($signed(m_axis_tdata[31:0]) >= -$signed(QuatOne)))
    else $error("quat_w out of range");

endmodule
